FILE: rtl/core/iafd_pkg.sv
// Shared types, constants and arithmetic helpers for the IMU angle frame decoder.
// Depends on nothing; every other file of the block imports this package.
`timescale 1ns / 1ps

package iafd_pkg;

  localparam int FRAME_LENGTH = 11;
  localparam int POS_W        = 4;
  localparam int DATA_DEPTH   = 8;
  localparam int DATA_IDX_W   = 3;

  // Byte positions inside a frame.
  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CRC_FIRST  = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_SAT        = POS_W'(FRAME_LENGTH);

  // Buffer slots, counted from the first stored byte.
  localparam logic [DATA_IDX_W-1:0] ROLL_IDX    = DATA_IDX_W'(0);
  localparam logic [DATA_IDX_W-1:0] PITCH_IDX   = DATA_IDX_W'(2);
  localparam logic [DATA_IDX_W-1:0] YAW_IDX     = DATA_IDX_W'(4);
  localparam logic [DATA_IDX_W-1:0] CRC_LOW_IDX = DATA_IDX_W'(FRAME_LENGTH - 2 - 3);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  localparam logic signed [9:0]  YAW_HALF_TURN = 10'sd180;
  localparam logic        [15:0] TURN_DEGREES  = 16'd360;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_continuous;
  } out_t;

  // Frame checker to angle unit.
  typedef struct packed {
    logic               done;
    logic               ok;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
  } frame_result_t;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // raw * 45 / 64, truncated toward zero: degrees with 7 fraction bits.
  function automatic logic signed [15:0] tilt_fixed(input logic signed [15:0] raw);
    logic signed [21:0] prod;
    logic signed [21:0] adj;
    prod = 22'(raw) * 22'sd45;
    adj  = prod[21] ? (prod + 22'sd63) : prod;
    return adj[21:6];
  endfunction

  // raw * 180 / 32768, truncated toward zero: whole degrees, -180..179.
  function automatic logic signed [8:0] yaw_degrees(input logic signed [15:0] raw);
    logic signed [23:0] prod;
    logic signed [23:0] adj;
    prod = 24'(raw) * 24'sd180;
    adj  = prod[23] ? (prod + 24'sd32767) : prod;
    return adj[23:15];
  endfunction

endpackage

FILE: rtl/core/iafd_frame.sv
// Frame tracker: byte position, running CRC, data byte buffer and the end-of-frame check.
// Depends on iafd_pkg.
`timescale 1ns / 1ps

module iafd_frame import iafd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  in_t           item,
  output frame_result_t frame
);

  logic [POS_W-1:0]      pos;
  logic [15:0]           crc;
  logic [7:0]            data_buf [DATA_DEPTH];
  logic [DATA_IDX_W-1:0] wr_index;
  logic                  is_byte;
  logic                  mid_byte;

  assign is_byte  = fire && (item.command == CMD_BYTE);
  assign mid_byte = is_byte && !item.frame_end;
  assign wr_index = pos[DATA_IDX_W-1:0] - POS_DATA_FIRST[DATA_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= CRC_INIT;
    end else if (is_byte) begin
      if (item.frame_end) begin
        pos <= '0;
        crc <= CRC_INIT;
      end else begin
        if (pos < POS_CRC_FIRST) begin
          crc <= crc_byte(crc, item.rx_byte);
        end
        if (pos <= POS_SAT) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // The buffer needs no reset: a frame that passes the length check has written
  // every slot that is read.
  always_ff @(posedge clk) begin
    if (mid_byte && pos >= POS_DATA_FIRST && pos <= POS_LAST) begin
      data_buf[wr_index] <= item.rx_byte;
    end
  end

  always_comb begin
    frame.done      = is_byte && item.frame_end;
    frame.ok        = frame.done && (pos == POS_LAST)
                      && ({item.rx_byte, data_buf[CRC_LOW_IDX]} == crc);
    frame.roll_raw  = {data_buf[ROLL_IDX],  data_buf[ROLL_IDX + DATA_IDX_W'(1)]};
    frame.pitch_raw = {data_buf[PITCH_IDX], data_buf[PITCH_IDX + DATA_IDX_W'(1)]};
    frame.yaw_raw   = {data_buf[YAW_IDX],   data_buf[YAW_IDX + DATA_IDX_W'(1)]};
  end

endmodule

FILE: rtl/core/iafd_angle.sv
// Angle unit: scales roll and pitch, unwraps yaw and keeps the held angles.
// Depends on iafd_pkg.
`timescale 1ns / 1ps

module iafd_angle import iafd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  in_t           item,
  input  frame_result_t frame,
  output out_t          result
);

  logic signed [15:0] held_roll;
  logic signed [15:0] held_pitch;
  logic signed [15:0] held_yaw;
  logic signed [8:0]  prev_yaw;
  logic        [15:0] turn_offset;   // turn count times 360, modulo 2^16

  logic signed [8:0]  yaw;
  logic signed [9:0]  delta;
  logic        [15:0] turn_offset_next;
  logic signed [15:0] roll_next;
  logic signed [15:0] pitch_next;
  logic signed [15:0] yaw_next;
  logic               clear;
  logic               update;

  assign clear  = fire && (item.command == CMD_RESET);
  assign update = frame.ok;

  always_comb begin
    yaw        = yaw_degrees(frame.yaw_raw);
    delta      = 10'(yaw) - 10'(prev_yaw);
    roll_next  = tilt_fixed(frame.roll_raw);
    pitch_next = tilt_fixed(frame.pitch_raw);
    if (delta > YAW_HALF_TURN) begin
      turn_offset_next = turn_offset - TURN_DEGREES;
    end else if (delta < -YAW_HALF_TURN) begin
      turn_offset_next = turn_offset + TURN_DEGREES;
    end else begin
      turn_offset_next = turn_offset;
    end
    yaw_next = 16'(yaw) + $signed(turn_offset_next);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held_roll   <= '0;
      held_pitch  <= '0;
      held_yaw    <= '0;
      prev_yaw    <= '0;
      turn_offset <= '0;
    end else if (update) begin
      held_roll   <= roll_next;
      held_pitch  <= pitch_next;
      held_yaw    <= yaw_next;
      prev_yaw    <= yaw;
      turn_offset <= turn_offset_next;
    end
  end

  always_comb begin
    result.frame_ok       = frame.ok;
    result.roll_angle     = update ? roll_next  : held_roll;
    result.pitch_angle    = update ? pitch_next : held_pitch;
    result.yaw_continuous = update ? yaw_next   : held_yaw;
  end

endmodule

FILE: rtl/core/imu_angle_frame_decoder_core.sv
// Top level of the IMU angle frame decoder: input register, frame tracker, angle unit
// and result register. Depends on iafd_pkg, iafd_frame and iafd_angle.
`timescale 1ns / 1ps

// The block takes the received bytes of an 11-byte Modbus RTU read response on the
// byte channel (byte_valid, byte_stall, byte_data), one byte or command per transfer.
// A byte with frame_end set closes the frame and produces one transfer on the result
// channel (result_valid, result_stall, result_data): frame_ok tells whether the
// length and CRC matched, and the roll, pitch and unwrapped yaw that are held after
// the frame. Other bytes and the reset-angles command produce no result.
//
// Each byte transfer lands in an input register; as it moves on, the CRC, frame
// check and angle math run in one pass and the result is loaded into the result
// register. A new byte can be taken every cycle while byte_stall is low, and the
// sustained rate is one byte per clock while the receiver does not stall results.
//
// When the receiver stalls a waiting result, the byte already in the input register
// still goes through if it makes no result; a byte that closes a frame waits, and
// byte_stall then rises until the result register is free.
// A synchronous rst empties both registers and clears the frame position, the CRC,
// the turn counter and the held angles.

module imu_angle_frame_decoder_core import iafd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  in_t  byte_data,
  output logic result_valid,
  input  logic result_stall,
  output out_t result_data
);

  logic          item_valid;
  in_t           item;
  logic          makes_result;
  logic          advance;
  frame_result_t frame;
  out_t          result;

  // A waiting item moves on unless it needs the result register while that is held.
  assign makes_result = (item.command == CMD_BYTE) && item.frame_end;
  assign advance      = item_valid && (!makes_result || !result_valid || !result_stall);
  assign byte_stall   = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      item <= byte_data;
    end
  end

  iafd_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (item),
    .frame (frame)
  );

  iafd_angle u_angle (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .frame  (frame),
    .result (result)
  );

  // The result register holds its transfer until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && makes_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && makes_result) begin
      result_data <= result;
    end
  end

endmodule

FILE: rtl/core/iafd_checker.sv
// Port-level checks for the IMU angle frame decoder, bound to the top level.
// Depends on iafd_pkg and imu_angle_frame_decoder_core.
`timescale 1ns / 1ps

module iafd_checker import iafd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic byte_valid,
  input logic byte_stall,
  input in_t  byte_data,
  input logic result_valid,
  input logic result_stall,
  input out_t result_data
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // The byte side only stalls behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("byte channel stalled without a held result");

  // A frame end taken while the result register is empty passes the input register and then shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && !result_valid
      && byte_data.command == CMD_BYTE && byte_data.frame_end |=> ##1 result_valid)
    else $error("frame end did not produce a result");

  // Held tilt angles stay within plus or minus 180 degrees.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.roll_angle >= -16'sd23040
      && result_data.roll_angle <= 16'sd23039
      && result_data.pitch_angle >= -16'sd23040
      && result_data.pitch_angle <= 16'sd23039)
    else $error("tilt angle out of range");

endmodule

bind imu_angle_frame_decoder_core iafd_checker u_iafd_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .byte_data    (byte_data),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);
